>>> design/sha256_stream_hasher_assert.svh
// Assertion macros for the stream hasher; empty when synthesising.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SHH_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shash: same-cycle check failed");
// next-cycle implication
`define SHH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shash: next-cycle check failed");
`else
`define SHH_ASSERT_IMPLY(label, ante, cons)
`define SHH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/shash_pkg.sv
`timescale 1ns / 1ps
package shash_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [7:0][31:0] t_hash;

    // controls from the sequencer to the round unit
    typedef struct packed {
        logic init;        // copy hash words into working variables
        logic round;       // run one compression round
        logic load_w;      // capture the next schedule word
        logic msg_w;       // next schedule word is a message word
        logic final_add;   // add working variables back into hash
        logic reset_hash;  // return to the initial hash values
    } t_core_ctl;

    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_FILL  = 6'd63;
    localparam logic [5:0] LEN_FILL   = 6'd56;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    // index 0 is the most significant digest word
    localparam t_hash HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sig0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sig1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sig0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sig1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

>>> design/shash_sched_mem.sv
`timescale 1ns / 1ps
module shash_sched_mem (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [3:0]  i_waddr,
    input  logic [31:0] i_wdata,
    input  logic [3:0]  i_raddr_a,
    input  logic [3:0]  i_raddr_b,
    output logic [31:0] o_rdata_a,
    output logic [31:0] o_rdata_b
);

    logic [31:0] r_mem [16];
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;

    // one write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

>>> design/shash_core.sv
`timescale 1ns / 1ps
module shash_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  shash_pkg::t_core_ctl  i_ctl,
    input  logic [5:0]            i_round,
    input  logic [31:0]           i_rd_a,
    input  logic [31:0]           i_rd_b,
    output logic [31:0]           o_next_w,
    output shash_pkg::t_hash      o_hash
);
    import shash_pkg::*;

    t_hash r_hash;
    t_hash n_hash_sum;
    t_hash r_wv;
    t_hash n_wv;
    t_word r_w;      // schedule word of the current round
    t_word r_wp;     // schedule word of the round before
    t_word r_w16;    // word sixteen back, from last cycle's port B read
    t_word t1;
    t_word t2;

    // next schedule word: message word, or the expansion recurrence
    always_comb begin
        if (i_ctl.msg_w) begin
            o_next_w = i_rd_a;
        end else begin
            o_next_w = small_sig1(r_wp) + i_rd_a + small_sig0(i_rd_b) + r_w16;
        end
    end

    // one compression round
    always_comb begin
        t1 = r_wv[7] + big_sig1(r_wv[4]) + ((r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]))
           + K_TABLE[i_round] + r_w;
        t2 = big_sig0(r_wv[0])
           + ((r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]));
        n_wv[0] = t1 + t2;
        n_wv[1] = r_wv[0];
        n_wv[2] = r_wv[1];
        n_wv[3] = r_wv[2];
        n_wv[4] = r_wv[3] + t1;
        n_wv[5] = r_wv[4];
        n_wv[6] = r_wv[5];
        n_wv[7] = r_wv[6];
    end

    // add-back at the end of a block
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            n_hash_sum[i] = r_hash[i] + r_wv[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= HASH_IV;
        end else if (i_ctl.reset_hash) begin
            r_hash <= HASH_IV;
        end else if (i_ctl.final_add) begin
            r_hash <= n_hash_sum;
        end
    end

    // working variables and schedule pipeline
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_wv <= r_hash;
        end else if (i_ctl.round) begin
            r_wv <= n_wv;
        end
        if (i_ctl.load_w) begin
            r_w  <= o_next_w;
            r_wp <= r_w;
        end
        r_w16 <= i_rd_b;
    end

    assign o_hash = r_hash;

endmodule

>>> design/sha256_stream_hasher.sv
// Message bytes: one item per cycle while a block fills. Each full 64-byte block then goes
// through load, prime, 64 rounds of the round unit and add-back, with input held off.
// Final item: one pad byte per cycle (up to 72), one or two block compressions, then the
// eight digest words leave an output buffer one per ready cycle, as a new message flows in.
// Schedule words sit in a 16-entry memory with two read ports, read one round ahead.
// Synchronous active-low reset: initial hash values, counters cleared, no clearing pass.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_assert.svh"
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import shash_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_PRIME = 7'b0001000,
        S_ROUND = 7'b0010000,
        S_FINAL = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state       r_state, n_state;
    logic [5:0]   r_fill, n_fill;
    logic [60:0]  r_count, n_count;
    logic [5:0]   r_round, n_round;
    logic         r_pad_act, n_pad_act;
    logic         r_pad_first, n_pad_first;
    logic         r_len_ok, n_len_ok;
    logic         r_done, n_done;
    logic         r_out_busy, n_out_busy;
    logic [2:0]   r_oidx, n_oidx;
    logic [23:0]  r_acc;
    t_hash        r_obuf;

    t_core_ctl    core_ctl;
    t_hash        hash;
    logic [31:0]  next_w;
    logic [31:0]  rd_a;
    logic [31:0]  rd_b;
    logic         mem_we;
    logic [3:0]   mem_waddr;
    logic [31:0]  mem_wdata;
    logic [3:0]   raddr_a;
    logic [3:0]   raddr_b;
    logic [5:0]   n_iss;
    logic [5:0]   n_cmp;
    logic         in_acc;
    logic         out_acc;
    logic         put_en;
    logic [7:0]   put_byte;
    logic [7:0]   pad_byte;
    logic [7:0]   len_byte;
    logic [63:0]  bit_len;
    logic [5:0]   len_sel;
    logic         sched_wr;
    logic         load_obuf;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign out_acc    = o_out_valid & i_out_ready;

    // padding byte source: 0x80, zero fill, then big-endian bit length
    assign bit_len  = {r_count, 3'b000};
    assign len_sel  = {3'd7 - r_fill[2:0], 3'b000};
    assign len_byte = bit_len[len_sel +: 8];

    always_comb begin
        if (r_pad_first) begin
            pad_byte = PAD_BYTE;
        end else if (r_len_ok && (r_fill >= LEN_FILL)) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = '0;
        end
    end

    assign put_en   = (in_acc && i_byte_valid) || (r_state == S_PAD);
    assign put_byte = (r_state == S_PAD) ? pad_byte : i_data_byte;

    // schedule read addresses, one round ahead of use
    always_comb begin
        case (r_state)
            S_LOAD:  n_iss = 6'd0;
            S_PRIME: n_iss = 6'd1;
            default: n_iss = r_round + 6'd2;
        endcase
        raddr_a = (n_iss[5:4] == 2'b00) ? n_iss[3:0] : (n_iss[3:0] - 4'd7);
        raddr_b = n_iss[3:0] + 4'd1;
        n_cmp   = (r_state == S_PRIME) ? 6'd0 : (r_round + 6'd1);
    end

    // round unit controls
    always_comb begin
        core_ctl            = '0;
        core_ctl.init       = (r_state == S_LOAD);
        core_ctl.round      = (r_state == S_ROUND);
        core_ctl.load_w     = (r_state == S_PRIME)
                            || ((r_state == S_ROUND) && (r_round != LAST_ROUND));
        core_ctl.msg_w      = (n_cmp[5:4] == 2'b00);
        core_ctl.final_add  = (r_state == S_FINAL);
        core_ctl.reset_hash = load_obuf;
    end

    assign load_obuf = (r_state == S_DONE) && !r_out_busy;

    // memory write: expanded schedule words in rounds, packed bytes otherwise
    assign sched_wr = (r_state == S_ROUND) && (r_round != LAST_ROUND) && (n_cmp[5:4] != 2'b00);

    always_comb begin
        if (sched_wr) begin
            mem_we    = 1'b1;
            mem_waddr = n_cmp[3:0];
            mem_wdata = next_w;
        end else begin
            mem_we    = put_en && (r_fill[1:0] == 2'b11);
            mem_waddr = r_fill[5:2];
            mem_wdata = {r_acc, put_byte};
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_count     = r_count;
        n_round     = r_round;
        n_pad_act   = r_pad_act;
        n_pad_first = r_pad_first;
        n_len_ok    = r_len_ok;
        n_done      = r_done;
        n_out_busy  = r_out_busy;
        n_oidx      = r_oidx;

        if (put_en) begin
            n_fill = r_fill + 6'd1;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_byte_valid) begin
                        n_count = r_count + 61'd1;
                    end
                    if (i_end_of_message) begin
                        n_pad_act   = 1'b1;
                        n_pad_first = 1'b1;
                        n_done      = 1'b0;
                    end
                    if (i_byte_valid && (r_fill == LAST_FILL)) begin
                        n_state = S_LOAD;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                n_pad_first = 1'b0;
                if (r_pad_first) begin
                    // 0x80 landing past the length slot forces a zero-filled block
                    n_len_ok = !((r_fill >= LEN_FILL) && (r_fill != LAST_FILL));
                end else if (r_fill == LAST_FILL) begin
                    n_len_ok = 1'b1;
                    if (r_len_ok) begin
                        n_done = 1'b1;
                    end
                end
                if (r_fill == LAST_FILL) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_PRIME;
            end
            S_PRIME: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_round = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (r_done) begin
                    n_state = S_DONE;
                end else if (r_pad_act) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                if (!r_out_busy) begin
                    n_count   = '0;
                    n_pad_act = 1'b0;
                    n_done    = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // output buffer drain
        if (load_obuf) begin
            n_out_busy = 1'b1;
            n_oidx     = '0;
        end else if (out_acc) begin
            n_oidx = r_oidx + 3'd1;
            if (r_oidx == 3'd7) begin
                n_out_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_count     <= '0;
            r_round     <= '0;
            r_pad_act   <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_done      <= 1'b0;
            r_out_busy  <= 1'b0;
            r_oidx      <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_round     <= n_round;
            r_pad_act   <= n_pad_act;
            r_pad_first <= n_pad_first;
            r_len_ok    <= n_len_ok;
            r_done      <= n_done;
            r_out_busy  <= n_out_busy;
            r_oidx      <= n_oidx;
        end
    end

    // byte packing and digest capture
    always_ff @(posedge i_clk) begin
        if (put_en) begin
            r_acc <= {r_acc[15:0], put_byte};
        end
        if (load_obuf) begin
            r_obuf <= hash;
        end
    end

    shash_sched_mem u_sched_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    shash_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (core_ctl),
        .i_round  (r_round),
        .i_rd_a   (rd_a),
        .i_rd_b   (rd_b),
        .o_next_w (next_w),
        .o_hash   (hash)
    );

    assign o_out_valid   = r_out_busy;
    assign o_digest_word = r_obuf[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    // checks
    `SHH_ASSERT_NEXT(a_round_end, (r_state == S_ROUND) && (r_round == LAST_ROUND), r_state == S_FINAL)
    `SHH_ASSERT_IMPLY(a_block_aligned, (r_state == S_LOAD) || (r_state == S_ROUND), r_fill == '0)
    `SHH_ASSERT_NEXT(a_digest_load, load_obuf, o_out_valid && (o_word_index == '0) && (r_state == S_IDLE))

endmodule

>>> test/tb_sha256_stream_hasher.sv
`timescale 1ns / 1ps
module tb_sha256_stream_hasher;

    localparam int STALL_LIMIT = 4000;  // cycles without any handshake
    localparam int TAIL_CYCLES = 300;   // pad bytes plus two compressions and the word buffer
    localparam int MSGS_PER_PHASE = 3;

    // well-known digests of the empty string and of "abc"
    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    localparam logic [31:0] SEED_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // lengths around the pad and length-field boundaries
    localparam int BOUNDARY_LENS [4] = '{55, 56, 63, 64};

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    typedef struct packed {
        logic [7:0]   data;
        logic         bvalid;
        logic         eom;
        logic         known;   // digest typed in below
        logic [255:0] digest;
    } t_stim_row;

    // directed items: one message per final flag
    t_stim_row directed_rows [14] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},   // empty message straight after reset
        '{8'hff, 1'b0, 1'b0, 1'b0, 256'd0},         // empty item, ignored
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'd0},
        '{8'haa, 1'b0, 1'b0, 1'b0, 256'd0},         // empty item inside a message
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'd0},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},     // final item carrying a byte
        '{8'h5a, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},   // final without byte, stale data
        '{8'h00, 1'b1, 1'b0, 1'b0, 256'd0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 256'd0},
        '{8'h80, 1'b0, 1'b1, 1'b0, 256'd0},         // final without byte after bytes
        '{8'hff, 1'b1, 1'b1, 1'b0, 256'd0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 256'd0},
        '{8'h55, 1'b0, 1'b0, 1'b0, 256'd0},
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}
    };

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_valid = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    int unsigned src_idle_pct = 7;
    int unsigned snk_idle_pct = 56;
    int unsigned stall_cycles = 0;
    int unsigned items_sent = 0;
    int unsigned messages_done = 0;
    int unsigned words_checked = 0;
    int unsigned bad_words = 0;

    // predictor state
    logic [31:0] run_hash [8];
    logic [7:0]  blk_bytes [64];
    int unsigned blk_fill;
    logic [60:0] msg_bytes;
    t_digest_word digest_due [$];

    always #10 i_clk = ~i_clk;

    sha256_stream_hasher u_top (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (data_byte),
        .i_byte_valid     (byte_valid),
        .i_end_of_message (end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        int i;
        for (i = 0; i < 8; i++) run_hash[i] = SEED_HASH[i];
        blk_fill  = 0;
        msg_bytes = '0;
    endfunction

    // 64-round compression of the gathered block into run_hash
    function automatic void compress_blk();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        int i;
        for (i = 0; i < 64; i++) begin
            if (i < 16) begin
                w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
            end else begin
                w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                     + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
            end
        end
        for (i = 0; i < 8; i++) v[i] = run_hash[i];
        for (i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (i = 0; i < 8; i++) run_hash[i] = run_hash[i] + v[i];
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        blk_bytes[blk_fill] = b;
        blk_fill++;
        if (blk_fill == 64) begin
            blk_fill = 0;
            compress_blk();
        end
    endfunction

    // Absorb one accepted item; on a final item queue the eight digest words.
    // A typed-in digest, where given, replaces the computed one.
    function automatic void absorb_item(input logic [7:0] d, input logic bv, input logic eom,
                                        input logic known, input logic [255:0] digest);
        logic [63:0] bit_len;
        t_digest_word dw;
        int i;
        if (bv) begin
            push_byte(d);
            msg_bytes = msg_bytes + 61'd1;
        end
        if (!eom) return;
        bit_len = {msg_bytes, 3'b000};
        push_byte(8'h80);
        while (blk_fill != 56) push_byte(8'h00);
        for (i = 0; i < 8; i++) push_byte(bit_len[63 - 8*i -: 8]);
        for (i = 0; i < 8; i++) begin
            dw.word = known ? digest[255 - 32*i -: 32] : run_hash[i];
            dw.idx  = i[2:0];
            dw.last = (i == 7);
            digest_due.push_back(dw);
        end
        messages_done++;
        restart_hash();
    endfunction

    function automatic void report_bad(input string what);
        bad_words++;
        if (bad_words <= 10) $display("[%0t] %s", $realtime, what);
    endfunction

    // Sender: random idle cycles, then hold the item until it is taken
    task automatic send_item(input logic [7:0] d, input logic bv, input logic eom,
                             input logic known, input logic [255:0] digest);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= d;
        byte_valid     <= bv;
        end_of_message <= eom;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        absorb_item(d, bv, eom, known, digest);
    endtask

    // One message of len bytes, with the odd empty item mixed in
    task automatic send_message(input int len);
        int i;
        int tail_byte;
        tail_byte = (len != 0) ? int'($urandom_range(1)) : 0;
        for (i = 0; i < len - tail_byte; i++) begin
            if ($urandom_range(9) == 0)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 256'd0);
            send_item(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, 256'd0);
        end
        send_item(8'($urandom_range(255)), tail_byte[0], 1'b1, 1'b0, 256'd0);
    endtask

    // Hold off the sender until every queued digest word has come out
    task automatic wait_digests();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (digest_due.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: check each accepted word against the oldest expectation
    always @(posedge i_clk) begin : digest_sink
        t_digest_word due;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_ready && o_out_valid) begin
                words_checked++;
                if (digest_due.size() == 0) begin
                    report_bad($sformatf("unexpected word %h idx %0d last %b",
                                         o_digest_word, o_word_index, o_last_word));
                end else begin
                    due = digest_due.pop_front();
                    if (o_digest_word !== due.word || o_word_index !== due.idx
                            || o_last_word !== due.last)
                        report_bad($sformatf(
                            "word: exp %h idx %0d last %b, got %h idx %0d last %b",
                            due.word, due.idx, due.last,
                            o_digest_word, o_word_index, o_last_word));
                end
            end
            out_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (out_ready && o_out_valid)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int r;
        int p;
        int k;
        int len;
        restart_hash();
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        for (r = 0; r < 14; r++)
            send_item(directed_rows[r].data, directed_rows[r].bvalid, directed_rows[r].eom,
                      directed_rows[r].known, directed_rows[r].digest);
        wait_digests();

        // random messages under three idling mixes; one block-boundary length overall
        for (p = 0; p < 3; p++) begin
            case (p)
                0: begin src_idle_pct = 7;  snk_idle_pct = 56; end
                1: begin src_idle_pct = 56; snk_idle_pct = 7;  end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            for (k = 0; k < MSGS_PER_PHASE; k++) begin
                if (p == 0 && k == 0)
                    len = BOUNDARY_LENS[$urandom_range(3)];
                else
                    len = $urandom_range(6);
                send_message(len);
            end
            wait_digests();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Hashed %0d messages from %0d items: directed vectors, then short messages",
                 messages_done, items_sent);
        $display("and one block-boundary length under three idling mixes; %0d words, %0d bad.",
                 words_checked, bad_words);
        if (bad_words == 0 && digest_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
